[rtl/mtt_pkg.sv]
// Shared types and constants for the markup tag tokenizer.
`timescale 1ns / 1ps

package mtt_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_END    = 3'd2;
    localparam logic [2:0] KIND_ANAME  = 3'd3;
    localparam logic [2:0] KIND_AVALUE = 3'd4;
    localparam logic [2:0] KIND_CLOSED = 3'd5;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       has;
        logic       tok_end;
    } res_t;

    // First result plus a flag for a trailing tag closed marker.
    typedef struct packed {
        res_t r0;
        logic two;
    } bundle_t;

    typedef struct packed {
        logic lt;
        logic gt;
        logic slash;
        logic stop;
        logic ws;
    } cls_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t k;
        k.lt    = (c == CH_LT);
        k.gt    = (c == CH_GT);
        k.slash = (c == CH_SLASH);
        k.stop  = (c == CH_EQ) || (c == CH_SPACE) || (c == CH_QUOTE);
        k.ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        return k;
    endfunction

endpackage

[rtl/mtt_front.sv]
// Front end: classify each byte, advance the parser mode, build a result bundle.
`timescale 1ns / 1ps

module mtt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    output logic             bundle_valid,
    output mtt_pkg::bundle_t bundle
);
    import mtt_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE        = 4'd0,
        M_TEXT        = 4'd1,
        M_LT          = 4'd2,
        M_START_NAME  = 4'd3,
        M_END_NAME    = 4'd4,
        M_ATTR_FIRST  = 4'd5,
        M_ATTR_NAME   = 4'd6,
        M_SKIP        = 4'd7,
        M_VALUE       = 4'd8,
        M_AFTER_VALUE = 4'd9
    } mode_t;

    mode_t mode_reg, mode_next;
    cls_t  k;

    always_comb
    begin
        k = classify(in_byte);
        mode_next = mode_reg;
        bundle_valid = 1'b0;
        bundle.two = 1'b0;
        bundle.r0.kind = KIND_TEXT;
        bundle.r0.data = 8'd0;
        bundle.r0.has = 1'b0;
        bundle.r0.tok_end = 1'b1;
        unique case (mode_reg)
            M_TEXT:
            begin
                bundle_valid = 1'b1;
                if (k.lt)
                begin
                    mode_next = M_LT;
                end
                else if (k.stop || k.gt)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    bundle.r0.data = in_byte;
                    bundle.r0.has = 1'b1;
                    bundle.r0.tok_end = 1'b0;
                end
            end
            M_LT, M_START_NAME:
            begin
                bundle.r0.kind = KIND_START;
                if (mode_reg == M_LT && k.slash)
                begin
                    mode_next = M_END_NAME;
                end
                else if (k.stop)
                begin
                    bundle_valid = 1'b1;
                    mode_next = M_ATTR_FIRST;
                end
                else if (k.gt)
                begin
                    bundle_valid = 1'b1;
                    bundle.two = 1'b1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    bundle_valid = 1'b1;
                    bundle.r0.data = in_byte;
                    bundle.r0.has = 1'b1;
                    bundle.r0.tok_end = 1'b0;
                    mode_next = M_START_NAME;
                end
            end
            M_END_NAME:
            begin
                bundle_valid = 1'b1;
                bundle.r0.kind = KIND_END;
                if (k.stop || k.gt)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    bundle.r0.data = in_byte;
                    bundle.r0.has = 1'b1;
                    bundle.r0.tok_end = 1'b0;
                end
            end
            M_ATTR_FIRST, M_ATTR_NAME:
            begin
                bundle_valid = 1'b1;
                bundle.r0.kind = KIND_ANAME;
                if (mode_reg == M_ATTR_FIRST && k.gt)
                begin
                    bundle.r0.kind = KIND_CLOSED;
                    mode_next = M_IDLE;
                end
                else if (k.stop)
                begin
                    mode_next = M_SKIP;
                end
                else if (k.gt)
                begin
                    mode_next = M_VALUE;
                end
                else
                begin
                    bundle.r0.data = in_byte;
                    bundle.r0.has = 1'b1;
                    bundle.r0.tok_end = 1'b0;
                    mode_next = M_ATTR_NAME;
                end
            end
            M_SKIP:
            begin
                mode_next = M_VALUE;
            end
            M_VALUE:
            begin
                bundle_valid = 1'b1;
                bundle.r0.kind = KIND_AVALUE;
                if (k.stop)
                begin
                    mode_next = M_AFTER_VALUE;
                end
                else if (k.gt)
                begin
                    bundle.two = 1'b1;
                    mode_next = M_IDLE;
                end
                else
                begin
                    bundle.r0.data = in_byte;
                    bundle.r0.has = 1'b1;
                    bundle.r0.tok_end = 1'b0;
                end
            end
            M_AFTER_VALUE:
            begin
                if (k.gt)
                begin
                    bundle_valid = 1'b1;
                    bundle.r0.kind = KIND_CLOSED;
                    mode_next = M_IDLE;
                end
                else
                begin
                    mode_next = M_ATTR_NAME;
                end
            end
            default:
            begin
                if (k.lt)
                begin
                    mode_next = M_LT;
                end
                else if (k.ws || k.gt)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    bundle_valid = 1'b1;
                    bundle.r0.data = in_byte;
                    bundle.r0.has = 1'b1;
                    bundle.r0.tok_end = 1'b0;
                    mode_next = M_TEXT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

[rtl/mtt_queue.sv]
// Short queue of result bundles between the front end and the back end.
`timescale 1ns / 1ps

module mtt_queue #(
    parameter int DEPTH = mtt_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  mtt_pkg::bundle_t wr_data,
    input  logic             rd_en,
    output mtt_pkg::bundle_t rd_data,
    output logic             full,
    output logic             empty
);
    import mtt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    bundle_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

[rtl/mtt_back.sv]
// Back end: unpack bundles into single results and hold them on the result ports.
`timescale 1ns / 1ps

module mtt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  mtt_pkg::bundle_t q_data,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output logic [2:0]       token_kind,
    output logic [7:0]       token_byte,
    output logic             has_byte,
    output logic             token_end,
    output logic             last_result
);
    import mtt_pkg::*;

    bundle_t cur_reg;
    logic    valid_reg;
    logic    idx_reg;
    logic    done;

    assign empty       = !valid_reg;
    assign last_result = idx_reg || !cur_reg.two;
    assign token_kind  = idx_reg ? KIND_CLOSED : cur_reg.r0.kind;
    assign token_byte  = idx_reg ? 8'd0 : cur_reg.r0.data;
    assign has_byte    = idx_reg ? 1'b0 : cur_reg.r0.has;
    assign token_end   = idx_reg ? 1'b1 : cur_reg.r0.tok_end;
    assign done        = valid_reg && pop && last_result;
    assign q_pop       = (!valid_reg || done) && !q_empty;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (valid_reg && pop)
        begin
            idx_reg <= 1'b1;
        end
    end

endmodule

[rtl/markup_tag_tokenizer.sv]
// Top level of the markup tag tokenizer.
`timescale 1ns / 1ps
//
// Input: one raw markup byte per request on in_byte, taken at a rising edge
// with push high and full low. Results: the oldest result sits on token_kind,
// token_byte, has_byte, token_end and last_result while empty is low, and is
// taken at a rising edge with pop high. A byte causes zero, one or two results;
// last_result marks the final one of each byte.
// Path: the first result of a byte is written into the bundle queue at the edge
// that takes the byte and moves on into the output stage once that stage is free.
// Throughput: one byte per cycle while full is low and each byte causes at most one
// result; the result port moves one result per cycle while pop is high, so a byte
// with two results holds it longer. The queue (QUEUE_DEPTH entries) absorbs this.
// When the receiver stalls, results wait in the output stage and the queue;
// full rises once the queue is filled and drops as results are popped.
// Reset clears the parser mode to idle between tokens and empties the queue
// and the output stage.
//
module markup_tag_tokenizer #(
    parameter int QUEUE_DEPTH = mtt_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] token_kind,
    output logic [7:0] token_byte,
    output logic       has_byte,
    output logic       token_end,
    output logic       last_result
);
    import mtt_pkg::*;

    logic    accept;
    logic    bundle_valid;
    bundle_t bundle;
    bundle_t q_data;
    logic    q_empty;
    logic    q_pop;

    assign accept = push && !full;

    mtt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    mtt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && bundle_valid),
        .wr_data (bundle),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    mtt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .token_kind  (token_kind),
        .token_byte  (token_byte),
        .has_byte    (has_byte),
        .token_end   (token_end),
        .last_result (last_result)
    );

endmodule

[rtl/mtt_checker.sv]
// Port-level assertions for the markup tag tokenizer, bound to the top level.
`timescale 1ns / 1ps

module mtt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] token_kind,
    input logic [7:0] token_byte,
    input logic       has_byte,
    input logic       token_end,
    input logic       last_result
);
    import mtt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(token_kind) && $stable(token_byte)
            && $stable(has_byte) && $stable(token_end) && $stable(last_result))
        else $error("waiting result changed");

    a_second_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_result |=> !empty && token_kind == KIND_CLOSED
            && token_end && !has_byte && last_result)
        else $error("second result is not a final tag closed marker");

    a_byte_xor_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(has_byte && token_end) && (has_byte || token_end))
        else $error("result carries both or neither of byte and end");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> token_kind <= KIND_CLOSED)
        else $error("token kind out of range");

endmodule

bind markup_tag_tokenizer mtt_checker u_mtt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .token_kind  (token_kind),
    .token_byte  (token_byte),
    .has_byte    (has_byte),
    .token_end   (token_end),
    .last_result (last_result)
);
